/* hw/rtl/mtat_pkg.sv */
// ----------------------------------------------------------------------------
// mtat_pkg
// Types, codes and the byte classifier shared by the media type tokenizer.
// ----------------------------------------------------------------------------
package mtat_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] TokenLo = 8'd33;
  localparam logic [7:0] TokenHi = 8'd126;

  localparam logic [3:0] S_START   = 4'd0;
  localparam logic [3:0] S_TYPE    = 4'd1;
  localparam logic [3:0] S_TYPE_SP = 4'd2;
  localparam logic [3:0] S_SUB0    = 4'd3;
  localparam logic [3:0] S_SUB     = 4'd4;
  localparam logic [3:0] S_SUB_SP  = 4'd5;
  localparam logic [3:0] S_ATTR0   = 4'd6;
  localparam logic [3:0] S_ATTR    = 4'd7;
  localparam logic [3:0] S_ATTR_SP = 4'd8;
  localparam logic [3:0] S_VAL0    = 4'd9;
  localparam logic [3:0] S_VAL     = 4'd10;
  localparam logic [3:0] S_QVAL    = 4'd11;
  localparam logic [3:0] S_END     = 4'd12;

  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_TYPE = 3'd1;
  localparam logic [2:0] K_SUB  = 3'd2;
  localparam logic [2:0] K_ATTR = 3'd3;
  localparam logic [2:0] K_VAL  = 3'd4;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_TYPE  = 2'd1;
  localparam logic [1:0] EV_PARAM = 2'd2;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [2:0] append_kind;
    logic [7:0] data_byte;
    logic [1:0] field_event;
    logic       final_param;
    logic       error_flag;
    logic       ended;
  } res_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       token;
    logic       blank;
    logic       space;
    logic       slash;
    logic       semi;
    logic       equal;
    logic       quote;
  } cls_t;

  function automatic cls_t classify(input in_t beat);
    cls_t       c;
    logic [7:0] b;
    logic       special;
    b       = beat.byte_in;
    special = (b == "(") || (b == ")") || (b == "<") || (b == ">") ||
              (b == "@") || (b == ",") || (b == ";") || (b == ":") ||
              (b == "\\") || (b == "\"") || (b == "/") || (b == "[") ||
              (b == "]") || (b == "?") || (b == "=");
    c.data_byte = b;
    c.is_last   = beat.is_last;
    c.token     = (b >= TokenLo) && (b <= TokenHi) && !special;
    c.blank     = (b == 8'd32) || (b == 8'd9);
    c.space     = (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    c.slash     = (b == "/");
    c.semi      = (b == ";");
    c.equal     = (b == "=");
    c.quote     = (b == "\"");
    return c;
  endfunction

endpackage

/* hw/rtl/mtat_front.sv */
// ----------------------------------------------------------------------------
// mtat_front
// Accepts header bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mtat_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mtat_pkg::in_t item,
  output logic          full,
  output logic          head_valid,
  output mtat_pkg::cls_t head,
  input  logic          take
);
  import mtat_pkg::*;

  cls_t                 q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;
  logic                 push_ok;
  logic                 take_ok;

  assign full       = (count == QueueCntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign push_ok    = push && !full;
  assign take_ok    = take && head_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= classify(item);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QueueCntW'(push_ok) - QueueCntW'(take_ok);
    end
  end

endmodule

/* hw/rtl/mtat_back.sv */
// ----------------------------------------------------------------------------
// mtat_back
// Runs the tokenizer state machine and buffers results for the consumer.
// ----------------------------------------------------------------------------
module mtat_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  mtat_pkg::cls_t head,
  output logic           take,
  output logic           empty,
  input  logic           pop,
  output mtat_pkg::res_t result
);
  import mtat_pkg::*;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       fail;
  logic       fail_next;
  logic [2:0] kind;
  logic [1:0] ev;
  res_t       res;

  res_t       out_q [2];
  logic       out_wr;
  logic       out_rd;
  logic [1:0] out_count;
  logic       pop_ok;

  assign take   = head_valid && (out_count != 2'd2);
  assign empty  = (out_count == 2'd0);
  assign result = out_q[out_rd];
  assign pop_ok = pop && !empty;

  always_comb begin
    state_next = state;
    fail_next  = fail;
    kind       = K_NONE;
    ev         = EV_NONE;
    unique case (state)
      S_START: begin
        if (head.token) begin
          kind = K_TYPE; state_next = S_TYPE;
        end else if (head.space) begin
          fail_next = 1'b1;
        end
      end
      S_TYPE: begin
        if (head.blank) begin
          state_next = S_TYPE_SP;
        end else if (head.slash) begin
          state_next = S_SUB0;
        end else if (head.semi) begin
          ev = EV_TYPE; state_next = S_ATTR0;
        end else if (head.token) begin
          kind = K_TYPE;
        end else begin
          fail_next = 1'b1;
        end
      end
      S_TYPE_SP: begin
        if (head.slash) begin
          state_next = S_SUB0;
        end else if (head.semi) begin
          ev = EV_TYPE; state_next = S_ATTR0;
        end else if (!head.blank) begin
          fail_next = 1'b1;
        end
      end
      S_SUB0: begin
        if (head.token) begin
          kind = K_SUB; state_next = S_SUB;
        end else if (!head.blank) begin
          fail_next = 1'b1;
        end
      end
      S_SUB: begin
        if (head.semi) begin
          ev = EV_TYPE; state_next = S_ATTR0;
        end else if (head.blank) begin
          ev = EV_TYPE; state_next = S_SUB_SP;
        end else if (head.token) begin
          kind = K_SUB;
        end else begin
          fail_next = 1'b1;
        end
      end
      S_SUB_SP: begin
        if (head.semi) begin
          state_next = S_ATTR0;
        end else if (!head.blank) begin
          state_next = S_END;
        end
      end
      S_ATTR0: begin
        if (head.token) begin
          kind = K_ATTR; state_next = S_ATTR;
        end
      end
      S_ATTR: begin
        if (head.token) begin
          kind = K_ATTR;
        end else if (head.blank) begin
          state_next = S_ATTR_SP;
        end else if (head.equal) begin
          state_next = S_VAL0;
        end else begin
          fail_next = 1'b1;
        end
      end
      S_ATTR_SP: begin
        if (head.equal) begin
          state_next = S_VAL0;
        end else if (!head.blank) begin
          fail_next = 1'b1;
        end
      end
      S_VAL0: begin
        if (head.quote) begin
          state_next = S_QVAL;
        end else if (head.token) begin
          kind = K_VAL; state_next = S_VAL;
        end else begin
          fail_next = 1'b1;
        end
      end
      S_QVAL: begin
        if (head.quote) begin
          ev = EV_PARAM; state_next = S_SUB_SP;
        end else begin
          kind = K_VAL;
        end
      end
      S_VAL: begin
        if (head.token) begin
          kind = K_VAL;
        end else if (head.blank) begin
          ev = EV_PARAM; state_next = S_SUB_SP;
        end else if (head.semi) begin
          ev = EV_PARAM; state_next = S_ATTR0;
        end else begin
          fail_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.append_kind = kind;
    res.data_byte   = head.data_byte;
    res.field_event = ev;
    res.final_param = head.is_last && (state_next == S_VAL) && !fail_next;
    res.error_flag  = fail_next;
    res.ended       = (state_next >= S_END);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_q[out_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_START;
      fail      <= 1'b0;
      out_wr    <= 1'b0;
      out_rd    <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (take) begin
        state  <= head.is_last ? S_START : state_next;
        fail   <= head.is_last ? 1'b0 : fail_next;
        out_wr <= ~out_wr;
      end
      if (pop_ok) begin
        out_rd <= ~out_rd;
      end
      out_count <= out_count + 2'(take) - 2'(pop_ok);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_count != 2'd3)
    else $error("result buffer count out of range");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    take && head.is_last |=> (state == S_START) && !fail)
    else $error("last beat did not reset the parser");

  a_ended_no_append: assert property (@(posedge clk) disable iff (rst)
    take |-> !res.ended || ((res.append_kind == K_NONE) &&
                            (res.field_event == EV_NONE)))
    else $error("ended beat produced a token");

  a_final_needs_value: assert property (@(posedge clk) disable iff (rst)
    take && res.final_param |-> head.is_last && !res.error_flag)
    else $error("final parameter flagged without clean last beat");

endmodule

/* hw/rtl/media_type_attribute_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// media_type_attribute_tokenizer_unit
// Byte-serial tokenizer for media type headers with parameters.
//
// Input beats carry one header byte and a last mark. A beat is taken when
// push is high and full is low. Each beat yields exactly one result beat,
// which is presented while empty is low and taken when pop is high.
// Results name the field the byte joins, type and parameter completion
// events, a sticky error flag and an ended mark. A beat with the last mark
// closes an open unquoted value and returns the parser to its start state.
//
// A front stage classifies bytes into a four-entry queue; a back stage runs
// the state machine and writes a two-entry result buffer. One beat per cycle
// is sustained while the receiver keeps popping. A taken byte is registered
// in the input queue and then in the result buffer before it appears at the
// result ports. When the receiver stalls, the result buffer fills first and
// then the input queue, after which full goes high. Reset empties both queues
// and clears the parser state and the error flag.
// ----------------------------------------------------------------------------
module media_type_attribute_tokenizer_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mtat_pkg::in_t  item,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output mtat_pkg::res_t result
);
  import mtat_pkg::*;

  logic head_valid;
  cls_t head;
  logic take;

  mtat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  mtat_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the media type attribute tokenizer.
//
// A short table of header bytes walks the special cases: blanks before the
// type, junk before an attribute, quoted values without escapes, trailing
// junk that ends parsing, and the last mark that closes an unquoted value.
// Random headers follow, mostly well formed with random content, and some
// corrupted, cut short or pure noise. Each taken byte runs through a local
// copy of the tokenizer, and every result beat is compared field by field
// with the oldest prediction. Both sides idle at varying rates, the receiver
// once holds off long enough to fill the block, and the sender pauses until
// all results are back between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mtat_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RandomBeats  = 1100;
  localparam int PhaseCount   = 3;
  localparam int StallCycles  = 80;

  typedef struct packed {
    in_t  beat;
    logic pinned;
    res_t want;
  } row_t;

  logic clk;
  logic rst;
  logic push;
  in_t  item;
  logic full;
  logic empty;
  logic pop;
  res_t result;

  media_type_attribute_tokenizer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  logic [3:0] tok_state;
  logic       tok_err;
  res_t       expected_results[$];
  row_t       directed_rows[$];
  logic [7:0] hdr_bytes[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  stall_request;
  int  cycle_count;
  int  mismatches;
  int  beats_sent;
  int  headers_sent;
  int  results_checked;
  int  type_events;
  int  param_events;
  int  final_params;
  int  ended_results;
  int  error_results;
  int  full_stalls;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic is_token_byte(input logic [7:0] c);
    if (c < 8'd33 || c > 8'd126) return 1'b0;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=":
        return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic is_blank_byte(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  function automatic logic is_ws_byte(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic res_t tokenize_byte(input in_t beat);
    res_t       r;
    logic [7:0] c;
    logic [3:0] s;
    c           = beat.byte_in;
    s           = tok_state;
    r           = '0;
    r.data_byte = c;
    case (s)
      S_START: begin
        if (is_token_byte(c)) begin
          r.append_kind = K_TYPE;
          s = S_TYPE;
        end else if (is_ws_byte(c)) tok_err = 1'b1;
      end
      S_TYPE: begin
        if (is_blank_byte(c)) s = S_TYPE_SP;
        else if (c == "/") s = S_SUB0;
        else if (c == ";") begin
          r.field_event = EV_TYPE;
          s = S_ATTR0;
        end else if (is_token_byte(c)) r.append_kind = K_TYPE;
        else tok_err = 1'b1;
      end
      S_TYPE_SP: begin
        if (c == "/") s = S_SUB0;
        else if (c == ";") begin
          r.field_event = EV_TYPE;
          s = S_ATTR0;
        end else if (!is_blank_byte(c)) tok_err = 1'b1;
      end
      S_SUB0: begin
        if (is_token_byte(c)) begin
          r.append_kind = K_SUB;
          s = S_SUB;
        end else if (!is_blank_byte(c)) tok_err = 1'b1;
      end
      S_SUB: begin
        if (c == ";") begin
          r.field_event = EV_TYPE;
          s = S_ATTR0;
        end else if (is_blank_byte(c)) begin
          r.field_event = EV_TYPE;
          s = S_SUB_SP;
        end else if (is_token_byte(c)) r.append_kind = K_SUB;
        else tok_err = 1'b1;
      end
      S_SUB_SP: begin
        if (c == ";") s = S_ATTR0;
        else if (!is_blank_byte(c)) s = S_END;
      end
      S_ATTR0: begin
        if (is_token_byte(c)) begin
          r.append_kind = K_ATTR;
          s = S_ATTR;
        end
      end
      S_ATTR: begin
        if (is_token_byte(c)) r.append_kind = K_ATTR;
        else if (is_blank_byte(c)) s = S_ATTR_SP;
        else if (c == "=") s = S_VAL0;
        else tok_err = 1'b1;
      end
      S_ATTR_SP: begin
        if (c == "=") s = S_VAL0;
        else if (!is_blank_byte(c)) tok_err = 1'b1;
      end
      S_VAL0: begin
        if (c == "\"") s = S_QVAL;
        else if (is_token_byte(c)) begin
          r.append_kind = K_VAL;
          s = S_VAL;
        end else tok_err = 1'b1;
      end
      S_QVAL: begin
        if (c == "\"") begin
          r.field_event = EV_PARAM;
          s = S_SUB_SP;
        end else r.append_kind = K_VAL;
      end
      S_VAL: begin
        if (is_token_byte(c)) r.append_kind = K_VAL;
        else if (is_blank_byte(c)) begin
          r.field_event = EV_PARAM;
          s = S_SUB_SP;
        end else if (c == ";") begin
          r.field_event = EV_PARAM;
          s = S_ATTR0;
        end else tok_err = 1'b1;
      end
      default: ;
    endcase
    r.ended      = (s >= S_END);
    r.error_flag = tok_err;
    if (beat.is_last) begin
      r.final_param = (s == S_VAL) && !tok_err;
      tok_state     = S_START;
      tok_err       = 1'b0;
    end else begin
      tok_state = s;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_token();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    while (!is_token_byte(c)) c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? 8'h20 : 8'h09;
  endfunction

  task automatic build_header();
    int         style;
    int         cut;
    logic [7:0] c;
    hdr_bytes.delete();
    style = $urandom_range(0, 99);
    if (style < 10) begin
      repeat ($urandom_range(1, 12)) hdr_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 6)) hdr_bytes.push_back(pick_token());
    if ($urandom_range(0, 9) == 0) begin
      hdr_bytes.push_back(";");
    end else begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2)) hdr_bytes.push_back(pick_blank());
      hdr_bytes.push_back("/");
      if ($urandom_range(0, 6) == 0) hdr_bytes.push_back(pick_blank());
      repeat ($urandom_range(1, 6)) hdr_bytes.push_back(pick_token());
    end
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 2)) hdr_bytes.push_back(pick_blank());
      hdr_bytes.push_back(";");
      if ($urandom_range(0, 2) == 0) hdr_bytes.push_back(pick_blank());
      if ($urandom_range(0, 9) == 0) hdr_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 5)) hdr_bytes.push_back(pick_token());
      if ($urandom_range(0, 6) == 0) hdr_bytes.push_back(pick_blank());
      hdr_bytes.push_back("=");
      if ($urandom_range(0, 2) == 0) begin
        hdr_bytes.push_back("\"");
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(0, 255));
          while (c == "\"") c = 8'($urandom_range(0, 255));
          hdr_bytes.push_back(c);
        end
        hdr_bytes.push_back("\"");
      end else begin
        repeat ($urandom_range(1, 5)) hdr_bytes.push_back(pick_token());
      end
    end
    if ($urandom_range(0, 3) == 0) hdr_bytes.push_back(pick_blank());
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) hdr_bytes.push_back(8'($urandom_range(0, 255)));
    if (style < 25) begin
      hdr_bytes[$urandom_range(0, hdr_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (style < 32 && hdr_bytes.size() > 1) begin
      cut = $urandom_range(1, hdr_bytes.size() - 1);
      while (hdr_bytes.size() > cut) void'(hdr_bytes.pop_back());
    end
  endtask

  task automatic send_beat(input in_t beat, input logic pinned, input res_t want);
    res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= beat;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    predicted = tokenize_byte(beat);
    expected_results.push_back(pinned ? want : predicted);
    beats_sent++;
    if (beat.is_last) headers_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string field, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with nothing expected, expected none, actual %h",
               $time, got);
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (got.append_kind !== want.append_kind)
      report_field("append_kind", want.append_kind, got.append_kind);
    if (got.data_byte !== want.data_byte)
      report_field("data_byte", want.data_byte, got.data_byte);
    if (got.field_event !== want.field_event)
      report_field("field_event", want.field_event, got.field_event);
    if (got.final_param !== want.final_param)
      report_field("final_param", want.final_param, got.final_param);
    if (got.error_flag !== want.error_flag)
      report_field("error_flag", want.error_flag, got.error_flag);
    if (got.ended !== want.ended)
      report_field("ended", want.ended, got.ended);
    if (got.field_event == EV_TYPE) type_events++;
    if (got.field_event == EV_PARAM) param_events++;
    if (got.final_param) final_params++;
    if (got.ended) ended_results++;
    if (got.error_flag) error_results++;
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_result(result);
      if (stall_request) begin
        hold_left     = StallCycles;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int  phase;
    int  phase_beats;
    bit  stall_done;
    rst           = 1'b1;
    push          = 1'b0;
    item          = '0;
    tok_state     = S_START;
    tok_err       = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b0;
    stall_done    = 1'b0;

    // Pinned rows carry their expected beat; the rest use the predictor.
    directed_rows.push_back({8'h20, 1'b0, 1'b1, K_NONE, 8'h20, EV_NONE, 3'b010});
    directed_rows.push_back({8'h00, 1'b1, 1'b1, K_NONE, 8'h00, EV_NONE, 3'b010});
    directed_rows.push_back({8'hff, 1'b0, 1'b1, K_NONE, 8'hff, EV_NONE, 3'b000});
    directed_rows.push_back({"t",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"/",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"~",   1'b0, 1'b1, K_SUB, "~", EV_NONE, 3'b000});
    directed_rows.push_back({"!",   1'b0, 1'b1, K_SUB, "!", EV_NONE, 3'b000});
    directed_rows.push_back({" ",   1'b0, 1'b1, K_NONE, " ", EV_TYPE, 3'b000});
    directed_rows.push_back({";",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"@",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"a",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"=",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"\"",  1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"\\",  1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"\"",  1'b0, 1'b1, K_NONE, "\"", EV_PARAM, 3'b000});
    directed_rows.push_back({";",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"b",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"=",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"v",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"x",   1'b1, 1'b1, K_VAL, "x", EV_NONE, 3'b100});
    directed_rows.push_back({"a",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"\t",  1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"/",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"s",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({" ",   1'b0, 1'b0, 16'h0000});
    directed_rows.push_back({"z",   1'b0, 1'b1, K_NONE, "z", EV_NONE, 3'b001});
    directed_rows.push_back({"q",   1'b1, 1'b1, K_NONE, "q", EV_NONE, 3'b001});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 28;
    recv_idle_pct = 50;
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].want);
    drain_results();

    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_beats = 0;
      while (phase_beats < RandomBeats / PhaseCount) begin
        build_header();
        foreach (hdr_bytes[k]) begin
          send_beat({hdr_bytes[k], 1'(k == hdr_bytes.size() - 1)}, 1'b0, '0);
          phase_beats++;
          if (phase == PhaseCount - 1 && !stall_done && phase_beats >= 100) begin
            stall_request = 1'b1;
            stall_done    = 1'b1;
          end
        end
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d headers, checked %0d results, %0d input stalls.",
             beats_sent, headers_sent, results_checked, full_stalls);
    $display("Saw %0d type and %0d parameter events, %0d closing values,",
             type_events, param_events, final_params);
    $display("%0d ended results and %0d with error.", ended_results, error_results);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
